// ----- rtl/tcf_pkg.sv -----
// Shared types and constants for the complementary tilt filter.
// Holds the CORDIC vector type, the arctangent table and the control codes.
// No dependencies.
`default_nettype none

package tcf_pkg;

  // Vector width covers a 17 bit input scaled by 2^14 plus CORDIC gain growth.
  localparam int VEC_W = 34;
  localparam int ANG_W = 32;
  localparam int ATAN_ENTRIES = 28;

  // Angles are Q3.28 radians.
  localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;
  localparam logic [34:0] TWO_PI_Q28 = 35'd1686629713;

  // pi * 2^28 / (16 * 1000 * 180) in Q.16, turns rate times milliseconds into Q3.28.
  localparam logic [25:0] RATE_K_Q16 = 26'd19190098;

  // atan(2^-i) in Q3.28, rounded to nearest.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
    logic                    roll;
  } vec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEED_P,
    ST_FEED_R,
    ST_GYRO,
    ST_WRAP,
    ST_YAW,
    ST_WAIT,
    ST_LP_MUL,
    ST_LP_SUM,
    ST_FUSE_MUL,
    ST_FUSE_SUM
  } state_t;

  typedef enum logic [1:0] {
    REG_ACC_KEEP   = 2'd0,
    REG_GYRO_BLEND = 2'd1,
    REG_STEP_MS    = 2'd2,
    REG_Z_OFFSET   = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/tcf_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation with a fixed shift.
// Depends on tcf_pkg for the vector type and the arctangent table.
`default_nettype none

module tcf_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  input  tcf_pkg::vec_t src,
  output logic          dst_valid,
  output tcf_pkg::vec_t dst
);

  localparam logic signed [tcf_pkg::ANG_W-1:0] ANGLE = tcf_pkg::ATAN_TAB[SHIFT];

  logic signed [tcf_pkg::VEC_W-1:0] x;
  logic signed [tcf_pkg::VEC_W-1:0] y;
  logic signed [tcf_pkg::VEC_W-1:0] x_sh;
  logic signed [tcf_pkg::VEC_W-1:0] y_sh;
  logic signed [tcf_pkg::ANG_W-1:0] z;
  tcf_pkg::vec_t                    vec_next;

  always_comb begin
    x = src.x;
    y = src.y;
    z = src.z;
    x_sh = x >>> SHIFT;
    y_sh = y >>> SHIFT;
    vec_next = src;
    // Rotate toward the x axis; a vector on the axis turns counterclockwise.
    if (!y[tcf_pkg::VEC_W-1] && (y != '0)) begin
      vec_next.x = x + y_sh;
      vec_next.y = y - x_sh;
      vec_next.z = z + ANGLE;
    end else begin
      vec_next.x = x - y_sh;
      vec_next.y = y + x_sh;
      vec_next.z = z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    dst <= vec_next;
  end

endmodule

`default_nettype wire

// ----- rtl/imu_complementary_tilt_filter.sv -----
// Top level of the complementary pitch, roll and yaw filter.
// Depends on tcf_pkg and tcf_cell (the CORDIC chain).
//
// One IMU sample is taken per transaction and one pitch/roll/yaw result is
// produced for it. The block works on one sample at a time: the next sample is
// accepted only after the previous result has been loaded into the output
// register. The pitch and roll vectors pass one after the other through the
// chain of CORDIC_STEPS cells, followed by the low-pass and blend multiply
// stages. A finished result waits in the output register while the next
// sample is accepted; only a second result that finds the first one still
// untaken holds the block. Configuration registers may be written whenever
// no sample is in flight.
`default_nettype none

module imu_complementary_tilt_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pitch_out,
  output logic signed [15:0] roll_out,
  output logic signed [15:0] yaw_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int VEC_W = tcf_pkg::VEC_W;
  localparam int LANES = 3;
  localparam int LANE_PITCH = 0;
  localparam int LANE_ROLL = 1;
  localparam int LANE_YAW = 2;
  localparam logic [1:0] WRAP_TOP = 2'd3;
  // pi plus eight turns: moves the yaw sum into [0, 16 turns) before reduction.
  localparam logic signed [36:0] YAW_BIAS = 37'sd14336352561;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  tcf_pkg::state_t state;
  tcf_pkg::state_t state_next;
  logic            entry_valid;
  logic            out_load;
  logic            accept;

  // Configuration registers.
  logic [14:0]        acc_keep_weight;
  logic [14:0]        gyro_blend_weight;
  logic [9:0]         step_ms;
  logic signed [15:0] z_offset;

  // Filter state, Q3.28 radians.
  logic signed [31:0] acc_pitch;
  logic signed [31:0] acc_roll;
  logic signed [31:0] gyro_pitch;
  logic signed [31:0] gyro_roll;
  logic signed [31:0] gyro_yaw;

  // Sample held for the duration of the transaction.
  logic signed [15:0] smp_x;
  logic signed [15:0] smp_y;
  logic signed [16:0] smp_z;
  logic signed [15:0] rate_smp [LANES];

  logic signed [26:0] rate_step [LANES];
  logic signed [53:0] rate_full [LANES];
  logic signed [53:0] rate_rnd [LANES];
  logic signed [35:0] rate_inc [LANES];

  logic [34:0]        wrap_acc;
  logic [1:0]         wrap_cnt;
  logic [34:0]        wrap_mod;

  logic signed [36:0] gp_sum;
  logic signed [36:0] gr_sum;
  logic signed [36:0] yaw_sum;

  logic signed [31:0] ang_p;
  logic signed [31:0] ang_r;
  logic               roll_done;

  // CORDIC chain.
  logic signed [15:0]        sel_y;
  logic signed [VEC_W-1:0]   x0;
  logic signed [VEC_W-1:0]   y0;
  tcf_pkg::vec_t             entry;
  wire [CORDIC_STEPS-1:0]    cell_valid;
  wire tcf_pkg::vec_t        cell_vec [CORDIC_STEPS];
  tcf_pkg::vec_t             tail;
  logic signed [31:0]        tail_ang;

  // Shared multiply stage for the low-pass and the blend.
  logic [14:0]        coef;
  logic signed [15:0] coef_a;
  logic signed [16:0] coef_b;
  logic signed [31:0] opa_p;
  logic signed [31:0] opb_p;
  logic signed [31:0] opa_r;
  logic signed [31:0] opb_r;
  logic signed [47:0] mul_a_p;
  logic signed [48:0] mul_b_p;
  logic signed [47:0] mul_a_r;
  logic signed [48:0] mul_b_r;
  logic signed [49:0] mix_rnd;
  logic signed [49:0] mix_p;
  logic signed [49:0] mix_r;
  logic signed [32:0] yaw_rnd;

  assign accept = (state == tcf_pkg::ST_IDLE) && in_valid;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    entry_valid = 1'b0;
    out_load = 1'b0;
    case (state)
      tcf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = tcf_pkg::ST_FEED_P;
        end
      end
      tcf_pkg::ST_FEED_P: begin
        entry_valid = 1'b1;
        state_next = tcf_pkg::ST_FEED_R;
      end
      tcf_pkg::ST_FEED_R: begin
        entry_valid = 1'b1;
        state_next = tcf_pkg::ST_GYRO;
      end
      tcf_pkg::ST_GYRO: begin
        state_next = tcf_pkg::ST_WRAP;
      end
      tcf_pkg::ST_WRAP: begin
        if (wrap_cnt == '0) begin
          state_next = tcf_pkg::ST_YAW;
        end
      end
      tcf_pkg::ST_YAW: begin
        state_next = tcf_pkg::ST_WAIT;
      end
      tcf_pkg::ST_WAIT: begin
        if (roll_done) begin
          state_next = tcf_pkg::ST_LP_MUL;
        end
      end
      tcf_pkg::ST_LP_MUL: begin
        state_next = tcf_pkg::ST_LP_SUM;
      end
      tcf_pkg::ST_LP_SUM: begin
        state_next = tcf_pkg::ST_FUSE_MUL;
      end
      tcf_pkg::ST_FUSE_MUL: begin
        state_next = tcf_pkg::ST_FUSE_SUM;
      end
      tcf_pkg::ST_FUSE_SUM: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = tcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcf_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_keep_weight <= 15'd19661;
      gyro_blend_weight <= 15'd22938;
      step_ms <= 10'd100;
      z_offset <= 16'sd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        tcf_pkg::REG_ACC_KEEP:   acc_keep_weight <= cfg_data[14:0];
        tcf_pkg::REG_GYRO_BLEND: gyro_blend_weight <= cfg_data[14:0];
        tcf_pkg::REG_STEP_MS:    step_ms <= cfg_data[9:0];
        tcf_pkg::REG_Z_OFFSET:   z_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ sample latch
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_x <= accel_x;
      smp_y <= accel_y;
      smp_z <= {accel_z[15], accel_z} + {z_offset[15], z_offset};
      rate_smp[LANE_PITCH] <= rate_y;
      rate_smp[LANE_ROLL] <= rate_x;
      rate_smp[LANE_YAW] <= rate_z;
    end
  end

  // ------------------------------------------------------------ CORDIC chain
  // Pitch enters in one cycle and roll in the next; both share z.
  // A vector in the left half plane is turned by pi first.
  always_comb begin
    sel_y = (state == tcf_pkg::ST_FEED_R) ? smp_y : smp_x;
    x0 = {{(VEC_W-31){smp_z[16]}}, smp_z, 14'd0};
    y0 = {{(VEC_W-30){sel_y[15]}}, sel_y, 14'd0};
    entry.zero = (smp_z == '0) && (sel_y == '0);
    entry.roll = (state == tcf_pkg::ST_FEED_R);
    if (smp_z[16]) begin
      entry.x = -x0;
      entry.y = -y0;
      entry.z = sel_y[15] ? -tcf_pkg::PI_Q28 : tcf_pkg::PI_Q28;
    end else begin
      entry.x = x0;
      entry.y = y0;
      entry.z = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tcf_cell #(
        .SHIFT(i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .src_valid (entry_valid),
        .src       (entry),
        .dst_valid (cell_valid[i]),
        .dst       (cell_vec[i])
      );
    end else begin : g_body
      tcf_cell #(
        .SHIFT(i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .src_valid (cell_valid[i-1]),
        .src       (cell_vec[i-1]),
        .dst_valid (cell_valid[i]),
        .dst       (cell_vec[i])
      );
    end
  end

  // The arctangent of the zero vector is defined as zero.
  always_comb begin
    tail = cell_vec[CORDIC_STEPS-1];
    tail_ang = tail.zero ? '0 : tail.z;
  end

  always_ff @(posedge clk) begin
    if (cell_valid[CORDIC_STEPS-1]) begin
      if (tail.roll) begin
        ang_r <= tail_ang;
      end else begin
        ang_p <= tail_ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_done <= 1'b0;
    end else if (accept) begin
      roll_done <= 1'b0;
    end else if (cell_valid[CORDIC_STEPS-1] && tail.roll) begin
      roll_done <= 1'b1;
    end
  end

  // ------------------------------------------------------- rate integration
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rate_rnd[j] = rate_full[j] + 54'sd32768;
      rate_inc[j] = rate_rnd[j][51:16];
    end
    gp_sum = {{5{gyro_pitch[31]}}, gyro_pitch} + {rate_inc[LANE_PITCH][35], rate_inc[LANE_PITCH]};
    gr_sum = {{5{gyro_roll[31]}}, gyro_roll} + {rate_inc[LANE_ROLL][35], rate_inc[LANE_ROLL]};
    yaw_sum = {{5{gyro_yaw[31]}}, gyro_yaw} + {rate_inc[LANE_YAW][35], rate_inc[LANE_YAW]}
              + YAW_BIAS;
    wrap_mod = TWO_PI_SHIFTED(wrap_cnt);
  end

  function automatic logic [34:0] TWO_PI_SHIFTED(input logic [1:0] sh);
    return tcf_pkg::TWO_PI_Q28 << sh;
  endfunction

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      if (state == tcf_pkg::ST_FEED_P) begin
        rate_step[j] <= rate_smp[j] * $signed({1'b0, step_ms});
      end
      if (state == tcf_pkg::ST_FEED_R) begin
        rate_full[j] <= rate_step[j] * $signed({1'b0, tcf_pkg::RATE_K_Q16});
      end
    end
    // Yaw reduction: restoring subtraction of 8, 4, 2 and 1 turns.
    if (state == tcf_pkg::ST_GYRO) begin
      wrap_acc <= yaw_sum[34:0];
      wrap_cnt <= WRAP_TOP;
    end else if (state == tcf_pkg::ST_WRAP) begin
      if (wrap_acc >= wrap_mod) begin
        wrap_acc <= wrap_acc - wrap_mod;
      end
      wrap_cnt <= wrap_cnt - 2'd1;
    end
  end

  // ------------------------------------------------------ low-pass and blend
  always_comb begin
    coef = (state == tcf_pkg::ST_LP_MUL) ? acc_keep_weight : gyro_blend_weight;
    coef_a = {1'b0, coef};
    coef_b = 17'sd32768 - $signed({2'b00, coef});
    if (state == tcf_pkg::ST_LP_MUL) begin
      opa_p = acc_pitch;
      opb_p = ang_p;
      opa_r = acc_roll;
      opb_r = ang_r;
    end else begin
      opa_p = gyro_pitch;
      opb_p = acc_pitch;
      opa_r = gyro_roll;
      opb_r = acc_roll;
    end
    mix_rnd = (state == tcf_pkg::ST_LP_SUM) ? 50'sd16384 : 50'sd536870912;
    mix_p = {{2{mul_a_p[47]}}, mul_a_p} + {mul_b_p[48], mul_b_p} + mix_rnd;
    mix_r = {{2{mul_a_r[47]}}, mul_a_r} + {mul_b_r[48], mul_b_r} + mix_rnd;
    yaw_rnd = {gyro_yaw[31], gyro_yaw} + 33'sd16384;
  end

  always_ff @(posedge clk) begin
    if ((state == tcf_pkg::ST_LP_MUL) || (state == tcf_pkg::ST_FUSE_MUL)) begin
      mul_a_p <= coef_a * opa_p;
      mul_b_p <= coef_b * opb_p;
      mul_a_r <= coef_a * opa_r;
      mul_b_r <= coef_b * opb_r;
    end
  end

  // ------------------------------------------------------------ filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pitch <= '0;
      acc_roll <= '0;
      gyro_pitch <= '0;
      gyro_roll <= '0;
      gyro_yaw <= '0;
    end else begin
      if (state == tcf_pkg::ST_GYRO) begin
        gyro_pitch <= sat32(gp_sum);
        gyro_roll <= sat32(gr_sum);
      end
      if (state == tcf_pkg::ST_YAW) begin
        gyro_yaw <= $signed(wrap_acc[31:0]) - tcf_pkg::PI_Q28;
      end
      if (state == tcf_pkg::ST_LP_SUM) begin
        acc_pitch <= sat32({{2{mix_p[49]}}, mix_p[49:15]});
        acc_roll <= sat32({{2{mix_r[49]}}, mix_r[49:15]});
      end
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pitch_out <= sat16(mix_p[49:30]);
      roll_out <= sat16(mix_r[49:30]);
      yaw_out <= sat16({{2{yaw_rnd[32]}}, yaw_rnd[32:15]});
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcf_checker.sv -----
// Port-level checks for the complementary tilt filter, bound to the top level.
// Depends only on the ports of imu_complementary_tilt_filter.
`default_nettype none

module tcf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] yaw_out
);

  // pi in Q3.13, after rounding.
  localparam logic signed [15:0] YAW_LIMIT = 16'sd25736;

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output register not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(yaw_out))
    else $error("stalled result dropped or changed");

  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while one is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_out >= -YAW_LIMIT) && (yaw_out <= YAW_LIMIT))
    else $error("yaw outside plus or minus pi");

endmodule

bind imu_complementary_tilt_filter tcf_checker u_tcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .yaw_out   (yaw_out)
);

`default_nettype wire
